### rtl/krpl_pkg.sv
// package for the key range partition lookup block
// request codes, result word type and sequencer states; no dependencies
`default_nettype none
package krpl_pkg;

  localparam int unsigned ID_BITS = 16;
  localparam int unsigned REQ_BITS = 3;
  localparam int unsigned MAX_RESULTS = 64;  // cap on sibling words per request

  typedef enum logic [REQ_BITS-1:0] {
    REQ_CLEAR  = 3'd0,
    REQ_INSERT = 3'd1,
    REQ_LOCATE = 3'd2,
    REQ_GROUP  = 3'd3,
    REQ_SIBS   = 3'd4,
    REQ_SAME   = 3'd5
  } req_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_INS_SCAN,
    ST_INS_SHIFT,
    ST_INS_WRITE,
    ST_LOC_RD,
    ST_LOC_CMP,
    ST_FIND,
    ST_SIB_SCAN,
    ST_SAME_B,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic                found;
    logic [ID_BITS-1:0]  owner;
    logic [ID_BITS-1:0]  group;
    logic                same;
    logic                status;
    logic                last;
  } res_t;

endpackage
`default_nettype wire

### rtl/krpl_store.sv
// entry memory: start, end, owner and group held side by side in one word
// one write port and one registered read port; uses krpl_pkg
`default_nettype none
module krpl_store #(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned KW    = 64,
  parameter int unsigned AW    = 6
) (
  input  wire logic                        clk,
  input  wire logic                        we,
  input  wire logic [AW-1:0]               waddr,
  input  wire logic [2*KW+2*krpl_pkg::ID_BITS-1:0] wdata,
  input  wire logic [AW-1:0]               raddr,
  output logic      [2*KW+2*krpl_pkg::ID_BITS-1:0] rdata
);
  import krpl_pkg::*;

  logic [2*KW+2*ID_BITS-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

### rtl/key_range_partition_lookup.sv
// top level of the key range partition lookup block
// sequencer around krpl_store; uses krpl_pkg
//
// usage: one request word on the in_ channel gives one or more result words
// on the out_ channel, the final one with out_tlast high.
// requests: clear, insert (sorted by start, after equal starts, refused with
// status when full), locate (binary search, midpoint (lo+hi)/2), group-of,
// siblings (one word per sibling in table order) and same-group.
// all entries sit in one memory with a single registered read port,
// so timing is set by that port (n = entries in the table):
//   clear and refused insert: word ready the cycle after acceptance,
//   locate a read and a compare per probe (up to floor(log2(n))+1 probes)
//   and one more bound check when nothing matches, group-of a scan of up
//   to n entries, same-group two such scans,
//   insert a scan, a read and a write per entry moved, then one check
//   step and one write step,
//   siblings one find scan and one scan stopped at MAX_RESULTS siblings;
//   each sibling word is held one behind so the final one can carry tlast.
// a request that leaves idle passes through ST_EMIT before the next accept.
// one request is worked at a time; in_tready is high only in idle with the
// output register free or being emptied.
// a result word waits in the output register while out_tready is low;
// the sequencer writes no further word until it is taken.
// reset clears the entry count and the sequencer; memory contents are not
// cleared, and no data beyond the entry count is ever used.
`default_nettype none
module key_range_partition_lookup #(
  parameter int unsigned MAX_ENTRIES = 64,
  parameter int unsigned KEY_BITS    = 64
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  // query_key[63:0], range_start[127:64], range_end[191:128], owner_id[207:192],
  // group_id[223:208], other_owner_id[239:224]
  input  wire logic [239:0] in_tdata,
  // req_type[2:0]
  input  wire logic [2:0]   in_tuser,
  output logic              out_tvalid,
  input  wire logic         out_tready,
  // found[0], result_owner_id[16:1], result_group_id[32:17], same_group[33],
  // status[34], zero fill [39:35]
  output logic [39:0]       out_tdata,
  output logic              out_tlast
);
  import krpl_pkg::*;

  localparam int unsigned AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int unsigned CW = $clog2(MAX_ENTRIES + 1);
  localparam int unsigned WW = 2 * KEY_BITS + 2 * ID_BITS;
  localparam int unsigned NW = $clog2(MAX_RESULTS + 1);

  // request fields, masked to KEY_BITS
  logic [KEY_BITS-1:0] f_key, f_rs, f_re;
  assign f_key = in_tdata[KEY_BITS-1:0];
  assign f_rs  = in_tdata[64+KEY_BITS-1:64];
  assign f_re  = in_tdata[128+KEY_BITS-1:128];

  // captured request
  logic [2:0]          req_r;
  logic [KEY_BITS-1:0] key_r, rs_r, re_r;
  logic [ID_BITS-1:0]  oid_r, gid_r, oid2_r;

  state_t state_r, state_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [CW-1:0] idx_r, idx_nxt;      // scan / shift pointer
  logic signed [CW:0] lo_r, lo_nxt, hi_r, hi_nxt;  // signed search bounds
  logic signed [CW+1:0] mid_sum;
  logic [AW-1:0] mid_r, mid_nxt;
  logic          rd_pend_r, rd_pend_nxt; // read data valid next cycle
  logic          fnd_a_r, fnd_a_nxt;
  logic [ID_BITS-1:0] grp_a_r, grp_a_nxt;
  logic          sibs_any_r, sibs_any_nxt;  // a sibling word is held
  logic [ID_BITS-1:0] sib_r, sib_nxt;       // held sibling id
  logic [NW-1:0] sib_n_r, sib_n_nxt;        // siblings found so far
  logic [CW-1:0] pos_r, pos_nxt;

  res_t res_r, res_nxt;
  logic ov_r, ov_nxt;                  // output register holds a word
  logic emit_done_r, emit_done_nxt;    // after emit go idle

  // memory
  logic          we;
  logic [AW-1:0] waddr, raddr;
  logic [WW-1:0] wdata, rdata;

  krpl_store #(.DEPTH(MAX_ENTRIES), .KW(KEY_BITS), .AW(AW)) u_store (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
  );

  logic [KEY_BITS-1:0] rd_start, rd_end;
  logic [ID_BITS-1:0]  rd_owner, rd_group;
  assign rd_start = rdata[KEY_BITS-1:0];
  assign rd_end   = rdata[2*KEY_BITS-1:KEY_BITS];
  assign rd_owner = rdata[2*KEY_BITS+ID_BITS-1:2*KEY_BITS];
  assign rd_group = rdata[WW-1:2*KEY_BITS+ID_BITS];

  logic out_free;
  assign out_free = !ov_r || out_tready;
  assign in_tready = (state_r == ST_IDLE) && out_free;
  assign out_tvalid = ov_r;
  assign out_tdata = {5'd0, res_r.status, res_r.same, res_r.group, res_r.owner, res_r.found};
  assign out_tlast = res_r.last;

  logic [CW-1:0] idx_prev;  // entry whose data arrives now
  assign idx_prev = idx_r - CW'(1);

  // bounds are never negative when a midpoint is taken
  assign mid_sum = (CW+2)'(lo_r) + (CW+2)'(hi_r);

  logic sib_hit;  // entry just read is a sibling
  assign sib_hit = rd_pend_r && (rd_group == grp_a_r) && (rd_owner != oid_r);

  // next state and datapath
  always_comb begin
    state_nxt = state_r;
    count_nxt = count_r;
    idx_nxt = idx_r;
    lo_nxt = lo_r; hi_nxt = hi_r; mid_nxt = mid_r;
    rd_pend_nxt = 1'b0;
    fnd_a_nxt = fnd_a_r; grp_a_nxt = grp_a_r;
    sibs_any_nxt = sibs_any_r;
    sib_nxt = sib_r;
    sib_n_nxt = sib_n_r;
    pos_nxt = pos_r;
    res_nxt = res_r;
    ov_nxt = ov_r && !out_tready;
    emit_done_nxt = emit_done_r;
    we = 1'b0; waddr = '0; wdata = '0; raddr = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_tvalid && out_free) begin
          idx_nxt = '0;
          fnd_a_nxt = 1'b0;
          sibs_any_nxt = 1'b0;
          sib_n_nxt = '0;
          unique case (in_tuser)
            REQ_CLEAR: begin
              count_nxt = '0;
              res_nxt = '{default: '0, last: 1'b1};
              ov_nxt = 1'b1;
            end
            REQ_INSERT: begin
              if (count_r >= CW'(MAX_ENTRIES)) begin
                res_nxt = '{default: '0, status: 1'b1, last: 1'b1};
                ov_nxt = 1'b1;
              end else begin
                state_nxt = ST_INS_SCAN;
              end
            end
            REQ_LOCATE: begin
              lo_nxt = '0;
              hi_nxt = $signed({1'b0, count_r}) - $signed((CW+1)'(1));
              state_nxt = ST_LOC_RD;
            end
            REQ_GROUP, REQ_SIBS, REQ_SAME: state_nxt = ST_FIND;
            default: ;
          endcase
        end
      end
      ST_INS_SCAN: begin
        // read start column in order; stop at first start > rs
        raddr = idx_r[AW-1:0];
        if (rd_pend_r && rd_start > rs_r) begin
          pos_nxt = idx_prev;
          idx_nxt = count_r;
          state_nxt = ST_INS_SHIFT;
        end else if (idx_r >= count_r) begin
          if (rd_pend_r || count_r == '0 || idx_r == '0) begin
            pos_nxt = count_r;
            idx_nxt = count_r;
            state_nxt = ST_INS_SHIFT;
          end
        end else begin
          idx_nxt = idx_r + CW'(1);
          rd_pend_nxt = 1'b1;
        end
        if (idx_r >= count_r && rd_pend_r && !(rd_start > rs_r)) begin
          pos_nxt = count_r;
          idx_nxt = count_r;
          state_nxt = ST_INS_SHIFT;
        end
      end
      ST_INS_SHIFT: begin
        // move entry idx-1 to idx, from the top down, one read and write each
        if (rd_pend_r) begin
          we = 1'b1;
          waddr = idx_r[AW-1:0];
          wdata = rdata;
          idx_nxt = idx_prev;
        end else if (idx_r > pos_r) begin
          raddr = idx_prev[AW-1:0];
          rd_pend_nxt = 1'b1;
        end else begin
          state_nxt = ST_INS_WRITE;
        end
      end
      ST_INS_WRITE: begin
        we = 1'b1;
        waddr = pos_r[AW-1:0];
        wdata = {gid_r, oid_r, re_r, rs_r};
        count_nxt = count_r + CW'(1);
        res_nxt = '{default: '0, last: 1'b1};
        ov_nxt = 1'b1;
        state_nxt = ST_EMIT;
      end
      ST_LOC_RD: begin
        if (lo_r > hi_r) begin
          res_nxt = '{default: '0, last: 1'b1};
          ov_nxt = 1'b1;
          state_nxt = ST_EMIT;
        end else begin
          mid_nxt = mid_sum[AW:1];
          raddr = mid_sum[AW:1];
          state_nxt = ST_LOC_CMP;
        end
      end
      ST_LOC_CMP: begin
        if (key_r < rd_start) begin
          hi_nxt = $signed((CW+1)'(mid_r)) - $signed((CW+1)'(1));
          state_nxt = ST_LOC_RD;
        end else if (key_r > rd_end) begin
          lo_nxt = $signed((CW+1)'(mid_r)) + $signed((CW+1)'(1));
          state_nxt = ST_LOC_RD;
        end else begin
          res_nxt = '{default: '0, found: 1'b1, owner: rd_owner, last: 1'b1};
          ov_nxt = 1'b1;
          state_nxt = ST_EMIT;
        end
      end
      ST_FIND, ST_SAME_B: begin
        // first entry holding the id (oid, or oid2 in the second pass)
        raddr = idx_r[AW-1:0];
        if (rd_pend_r && rd_owner == ((state_r == ST_SAME_B) ? oid2_r : oid_r)) begin
          if (state_r == ST_SAME_B) begin
            res_nxt = '{default: '0, found: fnd_a_r && (rd_group == grp_a_r),
                        same: fnd_a_r && (rd_group == grp_a_r), last: 1'b1};
            ov_nxt = 1'b1;
            state_nxt = ST_EMIT;
          end else if (req_r == REQ_GROUP) begin
            res_nxt = '{default: '0, found: 1'b1, group: rd_group, last: 1'b1};
            ov_nxt = 1'b1;
            state_nxt = ST_EMIT;
          end else begin
            fnd_a_nxt = 1'b1;
            grp_a_nxt = rd_group;
            idx_nxt = '0;
            state_nxt = (req_r == REQ_SIBS) ? ST_SIB_SCAN : ST_SAME_B;
          end
        end else if (idx_r >= count_r) begin
          if (state_r == ST_FIND && req_r == REQ_SAME) begin
            idx_nxt = '0;
            state_nxt = ST_SAME_B;  // a missing: result is 0 anyway
          end else begin
            res_nxt = '{default: '0, last: 1'b1};
            ov_nxt = 1'b1;
            state_nxt = ST_EMIT;
          end
        end else begin
          idx_nxt = idx_r + CW'(1);
          rd_pend_nxt = 1'b1;
        end
      end
      ST_SIB_SCAN: begin
        // a new hit sends the held word on and takes its place
        raddr = idx_r[AW-1:0];
        if (sib_hit && sibs_any_r && !out_free) begin
          // output busy: read the same entry again and wait
          raddr = idx_prev[AW-1:0];
          rd_pend_nxt = 1'b1;
        end else begin
          if (sib_hit) begin
            if (sibs_any_r) begin
              res_nxt = '{default: '0, found: 1'b1, owner: sib_r, last: 1'b0};
              ov_nxt = 1'b1;
            end
            sib_nxt = rd_owner;
            sibs_any_nxt = 1'b1;
            sib_n_nxt = sib_n_r + NW'(1);
          end
          if (idx_r < count_r && sib_n_nxt < NW'(MAX_RESULTS)) begin
            idx_nxt = idx_r + CW'(1);
            rd_pend_nxt = 1'b1;
          end else begin
            state_nxt = ST_EMIT;
            emit_done_nxt = 1'b0;
          end
        end
      end
      ST_EMIT: begin
        // siblings: the held word goes out marked last, or a none-found word
        if (req_r == REQ_SIBS && fnd_a_r && !emit_done_r) begin
          if (out_free) begin
            if (sibs_any_r) begin
              res_nxt = '{default: '0, found: 1'b1, owner: sib_r, last: 1'b1};
            end else begin
              res_nxt = '{default: '0, last: 1'b1};
            end
            ov_nxt = 1'b1;
            emit_done_nxt = 1'b1;
          end
        end else if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      count_r <= '0;
      ov_r <= 1'b0;
      rd_pend_r <= 1'b0;
      emit_done_r <= 1'b1;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      ov_r <= ov_nxt;
      rd_pend_r <= rd_pend_nxt;
      emit_done_r <= (state_r == ST_IDLE) ? 1'b1 : emit_done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      req_r <= in_tuser;
      key_r <= f_key; rs_r <= f_rs; re_r <= f_re;
      oid_r <= in_tdata[207:192];
      gid_r <= in_tdata[223:208];
      oid2_r <= in_tdata[239:224];
    end
    idx_r <= idx_nxt; lo_r <= lo_nxt; hi_r <= hi_nxt; mid_r <= mid_nxt;
    fnd_a_r <= fnd_a_nxt; grp_a_r <= grp_a_nxt; sibs_any_r <= sibs_any_nxt;
    sib_r <= sib_nxt; sib_n_r <= sib_n_nxt;
    pos_r <= pos_nxt; res_r <= res_nxt;
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(MAX_ENTRIES)) else $error("entry count above table size");
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_IDLE) |-> !in_tready) else $error("accept while busy");
  a_insert_grows: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_INS_WRITE) |=> (count_r == $past(count_r) + CW'(1)))
    else $error("insert did not grow count");
  a_write_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    we |-> (CW'(waddr) <= count_r)) else $error("write beyond table end");
`endif
endmodule
`default_nettype wire
